// ===== rtl/hit_position_to_voxel_top_assert.svh =====
// Assertion macros for the hit position to voxel block.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef HIT_POSITION_TO_VOXEL_TOP_ASSERT_SVH
`define HIT_POSITION_TO_VOXEL_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define HPTV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define HPTV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hptv_pkg.sv =====
// Shared types, widths and constants of the hit position to voxel block.
// No dependencies.
`timescale 1ns / 1ps
package hptv_pkg;

    localparam int BARS_PER_PLANE_DEF = 50;
    localparam int DOUBLE_PLANES_DEF  = 30;
    localparam int BAR_LENGTH_DEF     = 16000;

    localparam int LW  = 20;  // length fields
    localparam int AW  = 16;  // angles and Q1.15 values
    localparam int CW  = 27;  // coordinates through the rotations
    localparam int PW  = 43;  // one rotation product
    localparam int SW  = 44;  // sum of two products
    localparam int EW  = 24;  // extent
    localparam int DW  = EW + 1;  // twice the extent
    localparam int D2W = 30;  // doubled shifted distance
    localparam int NW  = 33;  // dividend
    localparam int QW  = 8;   // quotient
    localparam int VW  = 6;   // voxel index

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [12:0] SIN_C = 13'd4640;

    localparam logic [3:0] REG_CENTER_X = 4'd0;
    localparam logic [3:0] REG_CENTER_Y = 4'd1;
    localparam logic [3:0] REG_FRONT_Z  = 4'd2;
    localparam logic [3:0] REG_ANGLE_X  = 4'd3;
    localparam logic [3:0] REG_ANGLE_Y  = 4'd4;
    localparam logic [3:0] REG_ANGLE_Z  = 4'd5;
    localparam logic [3:0] REG_PITCH_XY = 4'd6;
    localparam logic [3:0] REG_PITCH_Z  = 4'd7;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_cell_ctl;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
        logic          fix;
    } t_div;

endpackage

// ===== rtl/hptv_sincos.sv =====
// Four stage Q1.15 sine of a binary angle, polynomial on the quarter turn.
// Depends on hptv_pkg.
`timescale 1ns / 1ps
module hptv_sincos import hptv_pkg::*; (
    input  logic                 i_clk,
    input  logic [AW-1:0]        i_angle,
    output logic signed [AW-1:0] o_val
);

    logic [1:0]  q0;
    logic [14:0] r0;
    logic [14:0] rr;
    logic [29:0] sq;
    logic [27:0] pc;
    logic [30:0] pm;
    logic [31:0] ps;
    logic [16:0] s4;
    logic [14:0] sat;

    logic [1:0]  r_q1, r_q2, r_q3;
    logic [14:0] r_r1, r_r2, r_r3;
    logic [14:0] r_y21, r_y22;
    logic [15:0] r_inner2;
    logic [16:0] r_mid3;
    logic signed [AW-1:0] r_val;

    always_comb begin
        q0  = i_angle[15:14];
        r0  = {1'b0, i_angle[13:0]};
        rr  = q0[0] ? (15'd16384 - r0) : r0;
        sq  = {15'd0, rr} * {15'd0, rr};
        pc  = {13'd0, r_y21} * {15'd0, SIN_C};
        pm  = {16'd0, r_y22} * {15'd0, r_inner2};
        ps  = {17'd0, r_r3} * {15'd0, r_mid3};
        s4  = ps[31:15];
        sat = (s4 > 17'd32767) ? 15'h7fff : s4[14:0];
    end

    always_ff @(posedge i_clk) begin
        r_q1     <= q0;
        r_r1     <= rr;
        r_y21    <= sq[28:14];
        r_q2     <= r_q1;
        r_r2     <= r_r1;
        r_y22    <= r_y21;
        r_inner2 <= SIN_B - pc[27:14] * 16'd1;
        r_q3     <= r_q2;
        r_r3     <= r_r2;
        r_mid3   <= SIN_A - {1'b0, pm[29:14]};
        r_val    <= r_q3[1] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end

    assign o_val = r_val;

endmodule

// ===== rtl/hptv_rot_cell.sv =====
// One rotation cell: four products, then two rounded sums; third axis rides along.
// Depends on hptv_pkg.
`timescale 1ns / 1ps
module hptv_rot_cell import hptv_pkg::*; (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic signed [AW-1:0] i_cos,
    input  logic signed [AW-1:0] i_sin,
    input  t_coord               i_u,
    input  t_coord               i_v,
    input  t_coord               i_w,
    output t_coord               o_u,
    output t_coord               o_v,
    output t_coord               o_w
);

    localparam logic signed [SW-1:0] RND = SW'(16384);

    logic signed [PW-1:0] r_cu, r_sv, r_cv, r_su;
    t_coord               r_wa, r_u, r_v, r_w;
    logic signed [SW-1:0] sum_u, sum_v;

    always_comb begin
        sum_u = SW'(r_cu) + SW'(r_sv) + RND;
        sum_v = SW'(r_cv) - SW'(r_su) + RND;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_cu <= PW'(i_cos) * PW'(i_u);
            r_sv <= PW'(i_sin) * PW'(i_v);
            r_cv <= PW'(i_cos) * PW'(i_v);
            r_su <= PW'(i_sin) * PW'(i_u);
            r_wa <= i_w;
        end
        if (i_ctl.en_b) begin
            // floor of sum/2^15 after adding half
            r_u <= sum_u[15 +: CW];
            r_v <= sum_v[15 +: CW];
            r_w <= r_wa;
        end
    end

    assign o_u = r_u;
    assign o_v = r_v;
    assign o_w = r_w;

endmodule

// ===== rtl/hptv_div_cell.sv =====
// One restoring divider cell: settles one quotient bit and passes the remainder on.
// Depends on hptv_pkg.
`timescale 1ns / 1ps
module hptv_div_cell import hptv_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    logic [NW-1:0] ds;
    logic          take;
    t_div          n_d;
    t_div          r_d;

    always_comb begin
        ds   = NW'(i_d.den) << BIT;
        take = !i_d.fix && (i_d.rem >= ds);
        n_d  = i_d;
        if (take) begin
            n_d.rem      = i_d.rem - ds;
            n_d.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/hit_position_to_voxel_top.sv =====
// Top level of the hit position to voxel block: offset, three rotations, quantization.
// Depends on hptv_pkg, hptv_sincos, hptv_rot_cell, hptv_div_cell and the assert header.
//
// channel   dir  handshake               payload
// s_*       in   s_tvalid / s_tready     s_tdata: pos_x, pos_y, pos_z
// m_*       out  m_tvalid / m_tready     m_tdata: voxel_x, voxel_y, voxel_z
// cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One hit per cycle sustained while m_tready is high. Stages: offset, align, delays,
// three rotation cells of two stages each, range check, one divider cell per bit.
// Sine and cosine come from free running four stage units fed by the angle registers.
// Every stage has its own valid bit; a stage fills when it is empty or moves on, so
// bubbles close up and s_tready drops only when all stages are full and m_tready is low.
// Synchronous reset clears the valid bits, loads config defaults; no clearing pass.
`timescale 1ns / 1ps
`include "hit_position_to_voxel_top_assert.svh"
module hit_position_to_voxel_top import hptv_pkg::*; #(
    parameter int BARS_PER_PLANE = BARS_PER_PLANE_DEF,
    parameter int DOUBLE_PLANES  = DOUBLE_PLANES_DEF,
    parameter int BAR_LENGTH     = BAR_LENGTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // pos_x [19:0], pos_y [39:20], pos_z [59:40], zero
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,   // voxel_x [5:0], voxel_y [11:6], voxel_z [17:12], zero
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_index,
    input  logic [LW-1:0] i_cfg_data
);

    localparam logic [QW-1:0] NM1_XY = QW'(BARS_PER_PLANE - 1);
    localparam logic [QW-1:0] NM1_Z  = QW'(2 * DOUBLE_PLANES - 1);
    localparam int ST_RZ   = 4;
    localparam int ST_RY   = 6;
    localparam int ST_RX   = 8;
    localparam int ST_PREP = 10;
    localparam int ST_DIV  = 11;
    localparam int NS      = ST_DIV + QW;

    // configuration
    logic signed [LW-1:0] r_center_x, r_center_y, r_front_z;
    logic [AW-1:0]        r_angle_x, r_angle_y, r_angle_z;
    logic [AW-1:0]        r_pitch_xy, r_pitch_z;
    logic [EW-1:0]        r_half_z, r_ext_xy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_front_z  <= LW'(89600);
            r_angle_x  <= '0;
            r_angle_y  <= '0;
            r_angle_z  <= '0;
            r_pitch_xy <= AW'(320);
            r_pitch_z  <= AW'(320);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_X: r_center_x <= i_cfg_data;
                REG_CENTER_Y: r_center_y <= i_cfg_data;
                REG_FRONT_Z:  r_front_z  <= i_cfg_data;
                REG_ANGLE_X:  r_angle_x  <= i_cfg_data[AW-1:0];
                REG_ANGLE_Y:  r_angle_y  <= i_cfg_data[AW-1:0];
                REG_ANGLE_Z:  r_angle_z  <= i_cfg_data[AW-1:0];
                REG_PITCH_XY: r_pitch_xy <= i_cfg_data[AW-1:0];
                REG_PITCH_Z:  r_pitch_z  <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_half_z <= EW'(r_pitch_z) * EW'(DOUBLE_PLANES);
        r_ext_xy <= EW'(r_pitch_xy) * EW'(BARS_PER_PLANE);
    end

    // trig
    logic signed [AW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

    hptv_sincos u_sin_x (.i_clk(i_clk), .i_angle(r_angle_x), .o_val(sin_x));
    hptv_sincos u_cos_x (.i_clk(i_clk), .i_angle(r_angle_x + 16'd16384), .o_val(cos_x));
    hptv_sincos u_sin_y (.i_clk(i_clk), .i_angle(r_angle_y), .o_val(sin_y));
    hptv_sincos u_cos_y (.i_clk(i_clk), .i_angle(r_angle_y + 16'd16384), .o_val(cos_y));
    hptv_sincos u_sin_z (.i_clk(i_clk), .i_angle(r_angle_z), .o_val(sin_z));
    hptv_sincos u_cos_z (.i_clk(i_clk), .i_angle(r_angle_z + 16'd16384), .o_val(cos_z));

    // stage control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    assign en[NS-1] = !r_vld[NS-1] || m_tready;
    genvar gk;
    generate
        for (gk = 0; gk < NS - 1; gk++) begin : g_en
            assign en[gk] = !r_vld[gk] || en[gk+1];
        end
    endgenerate

    assign s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // offset and align
    logic signed [LW-1:0] in_px, in_py, in_pz;
    t_vec                 r_pipe [0:ST_RZ-1];

    assign in_px = s_tdata[19:0];
    assign in_py = s_tdata[39:20];
    assign in_pz = s_tdata[59:40];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pipe[0].x <= CW'(in_px) - CW'(r_center_x);
            r_pipe[0].y <= CW'(in_py) - CW'(r_center_y);
            r_pipe[0].z <= CW'(in_pz) - CW'(r_front_z);
        end
        if (en[1]) begin
            r_pipe[1].x <= r_pipe[0].x;
            r_pipe[1].y <= r_pipe[0].y;
            r_pipe[1].z <= r_pipe[0].z - t_coord'(r_half_z);
        end
        for (int k = 2; k < ST_RZ; k++) begin
            if (en[k]) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    // rotations: undo Z, then Y, then X
    t_coord rz_x, rz_y, rz_z, ry_x, ry_y, ry_z, rx_x, rx_y, rx_z;

    hptv_rot_cell u_rot_z (
        .i_clk(i_clk), .i_ctl({en[ST_RZ], en[ST_RZ+1]}),
        .i_cos(cos_z), .i_sin(sin_z),
        .i_u(r_pipe[ST_RZ-1].x), .i_v(r_pipe[ST_RZ-1].y), .i_w(r_pipe[ST_RZ-1].z),
        .o_u(rz_x), .o_v(rz_y), .o_w(rz_z)
    );

    hptv_rot_cell u_rot_y (
        .i_clk(i_clk), .i_ctl({en[ST_RY], en[ST_RY+1]}),
        .i_cos(cos_y), .i_sin(sin_y),
        .i_u(rz_z), .i_v(rz_x), .i_w(rz_y),
        .o_u(ry_z), .o_v(ry_x), .o_w(ry_y)
    );

    hptv_rot_cell u_rot_x (
        .i_clk(i_clk), .i_ctl({en[ST_RX], en[ST_RX+1]}),
        .i_cos(cos_x), .i_sin(sin_x),
        .i_u(ry_y), .i_v(ry_z), .i_w(ry_x),
        .o_u(rx_y), .o_v(rx_z), .o_w(rx_x)
    );

    // range check and dividend
    function automatic t_div quant_prep(input logic signed [D2W-1:0] d2,
                                        input logic [EW-1:0] ext,
                                        input logic [QW-1:0] nm1);
        logic [DW-1:0] den;
        logic          neg;
        logic          over;
        t_div          res;
        den  = {ext, 1'b0};
        neg  = d2 < 0;
        over = d2 > $signed({{(D2W - DW){1'b0}}, den});
        res.rem = NW'(d2[DW-1:0]) * NW'(nm1) + NW'(ext);
        res.den = den;
        res.fix = neg || over || (ext == '0);
        res.quo = over ? nm1 : '0;
        return res;
    endfunction

    logic signed [D2W-1:0] d2_x, d2_y, d2_z;
    logic [EW-1:0]         ext_z;
    t_div                  r_prep [0:2];
    t_div                  w_div  [0:2][0:QW-1];

    always_comb begin
        d2_x  = (D2W'(rx_x) <<< 1) + D2W'(BAR_LENGTH);
        d2_y  = (D2W'(rx_y) <<< 1) + D2W'(BAR_LENGTH);
        d2_z  = (D2W'(rx_z) + D2W'(r_half_z)) <<< 1;
        ext_z = {r_half_z[EW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_PREP]) begin
            r_prep[0] <= quant_prep(d2_x, r_ext_xy, NM1_XY);
            r_prep[1] <= quant_prep(d2_y, r_ext_xy, NM1_XY);
            r_prep[2] <= quant_prep(d2_z, ext_z, NM1_Z);
        end
    end

    // divider chains, quotient bits from the top down
    genvar ga, gj;
    generate
        for (ga = 0; ga < 3; ga++) begin : g_axis
            for (gj = 0; gj < QW; gj++) begin : g_bit
                hptv_div_cell #(.BIT(QW - 1 - gj)) u_div (
                    .i_clk(i_clk),
                    .i_en (en[ST_DIV+gj]),
                    .i_d  ((gj == 0) ? r_prep[ga] : w_div[ga][(gj == 0) ? 0 : gj-1]),
                    .o_d  (w_div[ga][gj])
                );
            end
        end
    endgenerate

    assign m_tvalid = r_vld[NS-1];
    assign m_tdata  = {6'd0, w_div[2][QW-1].quo[VW-1:0], w_div[1][QW-1].quo[VW-1:0],
                       w_div[0][QW-1].quo[VW-1:0]};

    `HPTV_ASSERT_NXT(a_accept_fills, s_tvalid && s_tready, r_vld[0], "accepted hit lost")
    `HPTV_ASSERT_IMP(a_full_stall, (&r_vld) && !m_tready, !s_tready, "accept into full pipe")
    `HPTV_ASSERT_IMP(a_range_x, m_tvalid && (BARS_PER_PLANE <= 64),
                     m_tdata[5:0] <= NM1_XY[VW-1:0], "voxel_x out of range")
    `HPTV_ASSERT_IMP(a_range_z, m_tvalid && (DOUBLE_PLANES <= 32),
                     m_tdata[17:12] <= NM1_Z[VW-1:0], "voxel_z out of range")

endmodule
